@@ sv/bmdeq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmdeq_pkg
// Shared widths, constants and control types of the button matrix debouncer.
// ----------------------------------------------------------------------------
package bmdeq_pkg;

	localparam int SCAN_BYTES_DEF  = 16;
	localparam int QUEUE_DEPTH_DEF = 256;

	localparam int IDX_W  = 4;
	localparam int BYTE_W = 8;
	localparam int CNT_W  = 4;
	localparam int BIT_W  = 3;

	localparam logic [BYTE_W-1:0] MASK_RESET = 8'h0F;
	localparam logic [BYTE_W-1:0] REL_BIT    = 8'h80;
	localparam logic [BYTE_W-1:0] ALL_ONES   = 8'hFF;

	localparam logic REQ_SCAN = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	typedef struct packed {
		logic push;
		logic pop;
	} queue_ctrl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	typedef struct packed {
		logic              rd_en;
		logic              wr_en;
		logic [IDX_W-1:0]  rd_addr;
		logic [IDX_W-1:0]  wr_addr;
	} db_ctrl_t;

endpackage

@@ sv/bmdeq_debounce_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmdeq_debounce_mem
// Per scan byte previous sample and stable state, one read and one write port,
// registered read. Entries not yet written read as all ones.
// ----------------------------------------------------------------------------
module bmdeq_debounce_mem #(
	parameter int SCAN_BYTES = bmdeq_pkg::SCAN_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bmdeq_pkg::db_ctrl_t          ctrl,
	input  logic [bmdeq_pkg::BYTE_W-1:0] wr_prev,
	input  logic [bmdeq_pkg::BYTE_W-1:0] wr_stable,
	output logic [bmdeq_pkg::BYTE_W-1:0] rd_prev,
	output logic [bmdeq_pkg::BYTE_W-1:0] rd_stable
);
	import bmdeq_pkg::*;

	localparam int AW = (SCAN_BYTES > 1) ? $clog2(SCAN_BYTES) : 1;

	logic [2*BYTE_W-1:0] mem [SCAN_BYTES];
	logic [SCAN_BYTES-1:0] vld_q;
	logic [2*BYTE_W-1:0] rdata_s1;
	logic                rvld_s1;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[ctrl.wr_addr[AW-1:0]] <= {wr_prev, wr_stable};
		end
		if (ctrl.rd_en) begin
			rdata_s1 <= mem[ctrl.rd_addr[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (ctrl.wr_en) begin
				vld_q[ctrl.wr_addr[AW-1:0]] <= 1'b1;
			end
			if (ctrl.rd_en) begin
				rvld_s1 <= vld_q[ctrl.rd_addr[AW-1:0]];
			end
		end
	end

	assign rd_prev   = rvld_s1 ? rdata_s1[2*BYTE_W-1:BYTE_W] : ALL_ONES;
	assign rd_stable = rvld_s1 ? rdata_s1[BYTE_W-1:0] : ALL_ONES;

endmodule

@@ sv/bmdeq_event_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmdeq_event_queue
// Ring queue of event codes in a single memory, one slot kept empty.
// Pop read data is registered and valid the cycle after the pop.
// ----------------------------------------------------------------------------
module bmdeq_event_queue #(
	parameter int QUEUE_DEPTH = bmdeq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bmdeq_pkg::queue_ctrl_t       ctrl,
	input  logic [bmdeq_pkg::BYTE_W-1:0] push_data,
	output logic [bmdeq_pkg::BYTE_W-1:0] pop_data,
	output bmdeq_pkg::queue_stat_t       stat
);
	import bmdeq_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	logic [BYTE_W-1:0] mem [QUEUE_DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [PW-1:0]     wr_nxt;
	logic [PW-1:0]     rd_nxt;

	assign wr_nxt = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
	assign rd_nxt = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;

	assign stat.full  = (wr_nxt == rd_ptr_q);
	assign stat.empty = (wr_ptr_q == rd_ptr_q);

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem[wr_ptr_q] <= push_data;
		end
		if (ctrl.pop) begin
			pop_data <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (ctrl.push) begin
				wr_ptr_q <= wr_nxt;
			end
			if (ctrl.pop) begin
				rd_ptr_q <= rd_nxt;
			end
		end
	end

endmodule

@@ sv/button_matrix_debounce_event_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_matrix_debounce_event_queue
// Two-sample debouncer for a scanned button matrix with an event ring queue.
// ----------------------------------------------------------------------------
// One request at a time, one result per request. A scan byte in range passes
// through a read of the debounce memory, then a walk of the changed bits from
// bit 0 up, one bit at a time with at most one queue write each, then the
// result load. A pop adds a registered queue memory read; an empty pop or an
// out-of-range scan goes straight to the result load. A finished result sits
// in the output register, so the next request is taken while it waits. No
// clearing pass after reset.
module button_matrix_debounce_event_queue #(
	parameter int SCAN_BYTES  = bmdeq_pkg::SCAN_BYTES_DEF,
	parameter int QUEUE_DEPTH = bmdeq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [bmdeq_pkg::BYTE_W-1:0] cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         req_type,
	input  logic [bmdeq_pkg::IDX_W-1:0]  byte_index,
	input  logic [bmdeq_pkg::BYTE_W-1:0] sample_byte,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         event_valid,
	output logic [bmdeq_pkg::BYTE_W-1:0] event_code,
	output logic                         queue_nonempty,
	output logic [bmdeq_pkg::CNT_W-1:0]  events_pushed,
	output logic [bmdeq_pkg::CNT_W-1:0]  events_dropped
);
	import bmdeq_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DBRD = 3'd1;
	localparam logic [2:0] ST_EMIT = 3'd2;
	localparam logic [2:0] ST_POP  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]        state_q;
	logic [BYTE_W-1:0] mask_q;
	logic [IDX_W-1:0]  idx_q;
	logic [BYTE_W-1:0] sample_q;
	logic [BYTE_W-1:0] st_q;
	logic [BYTE_W-1:0] chg_q;
	logic [BIT_W-1:0]  bit_q;
	logic [CNT_W-1:0]  pushed_q;
	logic [CNT_W-1:0]  dropped_q;
	logic [BYTE_W-1:0] code_q;
	logic              evv_q;
	logic              out_valid_q;

	db_ctrl_t          db_ctrl;
	logic [BYTE_W-1:0] db_prev;
	logic [BYTE_W-1:0] db_stable;
	logic [BYTE_W-1:0] db_chg;
	queue_ctrl_t       q_ctrl;
	queue_stat_t       q_stat;
	logic [BYTE_W-1:0] q_push_data;
	logic [BYTE_W-1:0] q_pop_data;

	logic              take;
	logic              in_range;
	logic [BYTE_W-1:0] sample_in;
	logic              cur_chg;
	logic              load_out;

	assign in_ready  = (state_q == ST_IDLE);
	assign take      = in_valid && in_ready;
	assign in_range  = ({1'b0, byte_index} < (IDX_W + 1)'(SCAN_BYTES));
	assign sample_in = (byte_index == IDX_W'(SCAN_BYTES - 1)) ?
	                   (sample_byte | mask_q) : sample_byte;

	assign db_chg  = ~(db_prev ^ sample_q) & (db_prev ^ db_stable);
	assign cur_chg = chg_q[bit_q];

	assign db_ctrl.rd_en   = take && (req_type != REQ_POP) && in_range;
	assign db_ctrl.rd_addr = byte_index;
	assign db_ctrl.wr_en   = (state_q == ST_DBRD);
	assign db_ctrl.wr_addr = idx_q;

	assign q_ctrl.pop  = take && (req_type == REQ_POP) && !q_stat.empty;
	assign q_ctrl.push = (state_q == ST_EMIT) && cur_chg && !q_stat.full;
	assign q_push_data = {~st_q[bit_q], idx_q, ~bit_q};

	assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	bmdeq_debounce_mem #(
		.SCAN_BYTES(SCAN_BYTES)
	) u_db_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (db_ctrl),
		.wr_prev   (sample_q),
		.wr_stable (db_stable ^ db_chg),
		.rd_prev   (db_prev),
		.rd_stable (db_stable)
	);

	bmdeq_event_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (q_ctrl),
		.push_data (q_push_data),
		.pop_data  (q_pop_data),
		.stat      (q_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= MASK_RESET;
		end else if (cfg_wr_en) begin
			mask_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (req_type == REQ_POP) begin
							state_q <= q_stat.empty ? ST_DONE : ST_POP;
						end else begin
							state_q <= in_range ? ST_DBRD : ST_DONE;
						end
					end
				end
				ST_DBRD: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (bit_q == '1) begin
						state_q <= ST_DONE;
					end
				end
				ST_POP: state_q <= ST_DONE;
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					idx_q     <= byte_index;
					sample_q  <= sample_in;
					pushed_q  <= '0;
					dropped_q <= '0;
					code_q    <= '0;
					evv_q     <= 1'b0;
				end
			end
			ST_DBRD: begin
				st_q  <= db_stable;
				chg_q <= db_chg;
				bit_q <= '0;
			end
			ST_EMIT: begin
				bit_q <= bit_q + 1'b1;
				if (cur_chg) begin
					if (q_stat.full) begin
						dropped_q <= dropped_q + 1'b1;
					end else begin
						pushed_q <= pushed_q + 1'b1;
					end
				end
			end
			ST_POP: begin
				code_q <= q_pop_data ^ REL_BIT;
				evv_q  <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			event_valid    <= evv_q;
			event_code     <= code_q;
			queue_nonempty <= !q_stat.empty;
			events_pushed  <= pushed_q;
			events_dropped <= dropped_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the button matrix debouncer with its event queue.
// Scan samples and pops go in over valid/ready. A behavioral copy of the
// debounce state and the ring queue predicts the result of every transfer,
// and each result is checked field by field in order. The run covers the
// empty and full queue, bounce, the last-byte mask at several settings, a
// long output stall and random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_top;
	import bmdeq_pkg::*;

	localparam int SCAN        = SCAN_BYTES_DEF;
	localparam int QDEPTH      = QUEUE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_ITEMS = 130;
	localparam int LONG_HOLD   = 400;
	localparam int SETTLE      = 24;

	typedef struct packed {
		logic              req;
		logic [IDX_W-1:0]  idx;
		logic [BYTE_W-1:0] smp;
	} host_req_t;

	typedef struct packed {
		logic              ev_valid;
		logic [BYTE_W-1:0] code;
		logic              nonempty;
		logic [CNT_W-1:0]  pushed;
		logic [CNT_W-1:0]  dropped;
	} key_result_t;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              cfg_wr_en   = 1'b0;
	logic [BYTE_W-1:0] cfg_wr_data = '0;
	logic              in_valid    = 1'b0;
	logic              in_ready;
	logic              req_type    = REQ_SCAN;
	logic [IDX_W-1:0]  byte_index  = '0;
	logic [BYTE_W-1:0] sample_byte = '0;
	logic              out_valid;
	logic              out_ready   = 1'b0;
	logic              event_valid;
	logic [BYTE_W-1:0] event_code;
	logic              queue_nonempty;
	logic [CNT_W-1:0]  events_pushed;
	logic [CNT_W-1:0]  events_dropped;

	host_req_t   pend_q[$];
	key_result_t expected_q[$];
	int errors        = 0;
	int cycles        = 0;
	int items_sent    = 0;
	bit in_taken      = 1'b0;
	int send_gap      = 0;
	bit send_burst    = 1'b0;
	int recv_gap      = 0;
	bit recv_burst    = 1'b0;
	int hold_requests = 0;
	int hold_served   = 0;
	int hold_left     = 0;

	// debounce and queue state of the predictor
	logic [BYTE_W-1:0] mask_model;
	logic [BYTE_W-1:0] prev_samp [SCAN];
	logic [BYTE_W-1:0] stable_bits [SCAN];
	logic [BYTE_W-1:0] event_ring [QDEPTH];
	int wr_ptr;
	int rd_ptr;

	button_matrix_debounce_event_queue dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.byte_index     (byte_index),
		.sample_byte    (sample_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.event_valid    (event_valid),
		.event_code     (event_code),
		.queue_nonempty (queue_nonempty),
		.events_pushed  (events_pushed),
		.events_dropped (events_dropped)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic key_result_t debounce_step(host_req_t r);
		key_result_t       res;
		logic [BYTE_W-1:0] smp;
		logic [BYTE_W-1:0] st;
		logic [BYTE_W-1:0] prev;
		logic [BYTE_W-1:0] change;
		logic [BYTE_W-1:0] ev;
		int                j;
		res = '0;
		if (r.req == REQ_POP) begin
			if (wr_ptr != rd_ptr) begin
				res.ev_valid = 1'b1;
				res.code     = event_ring[rd_ptr] ^ REL_BIT;
				rd_ptr       = (rd_ptr + 1) % QDEPTH;
			end
		end else if (int'(r.idx) < SCAN) begin
			smp = r.smp;
			if (int'(r.idx) == SCAN - 1)
				smp = smp | mask_model;
			prev   = prev_samp[r.idx];
			st     = stable_bits[r.idx];
			change = ~(prev ^ smp) & (prev ^ st);
			for (j = 0; j < BYTE_W; j++) begin
				if (change[j]) begin
					// stored code: bit 7 set on release (stable 0 -> 1)
					ev[6:0] = 7'(int'(r.idx) * 8 + 7 - j);
					ev[7]   = ~st[j];
					st[j]   = ~st[j];
					if ((wr_ptr + 1) % QDEPTH != rd_ptr) begin
						event_ring[wr_ptr] = ev;
						wr_ptr             = (wr_ptr + 1) % QDEPTH;
						res.pushed         = res.pushed + 1'b1;
					end else begin
						res.dropped = res.dropped + 1'b1;
					end
				end
			end
			stable_bits[r.idx] = st;
			prev_samp[r.idx]   = smp;
		end
		res.nonempty = (wr_ptr != rd_ptr);
		return res;
	endfunction

	function automatic int pick_gap(bit burst);
		int k;
		if (burst)
			return 0;
		k = $urandom_range(0, 99);
		if (k < 55)
			return 0;
		if (k < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic check_field(string name, logic [BYTE_W-1:0] want_v,
			logic [BYTE_W-1:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want_v,
				got_v);
			errors++;
		end
	endtask

	// monitor: output transfers are checked first, then an input transfer
	// is run through the predictor
	always @(posedge clk) begin
		key_result_t want;
		host_req_t   taken;
		if (out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, actual code %0h", $time, event_code);
				errors++;
			end else begin
				want = expected_q.pop_front();
				check_field("event_valid", BYTE_W'(want.ev_valid), BYTE_W'(event_valid));
				check_field("event_code", want.code, event_code);
				check_field("queue_nonempty", BYTE_W'(want.nonempty),
					BYTE_W'(queue_nonempty));
				check_field("events_pushed", BYTE_W'(want.pushed), BYTE_W'(events_pushed));
				check_field("events_dropped", BYTE_W'(want.dropped),
					BYTE_W'(events_dropped));
			end
		end
		in_taken = in_valid && in_ready;
		if (in_taken) begin
			taken = {req_type, byte_index, sample_byte};
			expected_q.push_back(debounce_step(taken));
		end
	end

	// driver
	always @(negedge clk) begin
		host_req_t r;
		if (!in_valid || in_taken) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pend_q.size() != 0) begin
				r = pend_q.pop_front();
				req_type    <= r.req;
				byte_index  <= r.idx;
				sample_byte <= r.smp;
				in_valid    <= 1'b1;
				send_gap = pick_gap(send_burst);
				if ($urandom_range(0, 49) == 0)
					send_burst = !send_burst;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left   = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 99) < 30)
				recv_gap = pick_gap(recv_burst);
			if ($urandom_range(0, 199) == 0)
				recv_burst = !recv_burst;
		end
	end

	task automatic push_scan(int idx, logic [BYTE_W-1:0] v);
		host_req_t r;
		r.req = REQ_SCAN;
		r.idx = IDX_W'(idx);
		r.smp = v;
		pend_q.push_back(r);
		items_sent++;
	endtask

	task automatic push_pops(int n);
		host_req_t r;
		r.req = REQ_POP;
		repeat (n) begin
			r.idx = IDX_W'($urandom);
			r.smp = BYTE_W'($urandom);
			pend_q.push_back(r);
			items_sent++;
		end
	endtask

	function automatic int pick_idx();
		if ($urandom_range(0, 4) == 0)
			return SCAN - 1;
		return $urandom_range(0, SCAN - 1);
	endfunction

	// full press then full release of random bytes, fills the queue fast
	task automatic flood(int n);
		int idx;
		repeat (n) begin
			idx = pick_idx();
			push_scan(idx, 8'h00);
			push_scan(idx, 8'h00);
			push_scan(idx, ALL_ONES);
			push_scan(idx, ALL_ONES);
		end
	endtask

	task automatic random_phase(int target);
		int                start;
		int                k;
		int                idx;
		logic [BYTE_W-1:0] v;
		start = items_sent;
		while (items_sent - start < target) begin
			k = $urandom_range(0, 99);
			if (k < 50) begin
				// debounced change, sometimes preceded by a bounce sample
				idx = pick_idx();
				case ($urandom_range(0, 3))
					0: v = 8'h00;
					1: v = ALL_ONES;
					default: v = BYTE_W'($urandom);
				endcase
				if ($urandom_range(0, 2) == 0)
					push_scan(idx, BYTE_W'($urandom));
				push_scan(idx, v);
				push_scan(idx, v);
				if ($urandom_range(0, 1) == 0)
					push_pops(1);
			end else if (k < 75) begin
				push_pops($urandom_range(1, 6));
			end else if (k < 83) begin
				flood($urandom_range(2, 8));
			end else if (k < 95) begin
				push_scan(pick_idx(), BYTE_W'($urandom));
			end else begin
				push_pops($urandom_range(20, 60));
			end
		end
	endtask

	task automatic wait_drained();
		while (pend_q.size() != 0 || in_valid || expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_mask(logic [BYTE_W-1:0] v);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		mask_model = v;
	endtask

	initial begin
		logic [BYTE_W-1:0] mask_plan [6];
		mask_model = MASK_RESET;
		for (int i = 0; i < SCAN; i++) begin
			prev_samp[i]   = ALL_ONES;
			stable_bits[i] = ALL_ONES;
		end
		wr_ptr = 0;
		rd_ptr = 0;
		mask_plan[0] = MASK_RESET;
		mask_plan[1] = 8'h00;
		mask_plan[2] = ALL_ONES;
		mask_plan[3] = BYTE_W'($urandom);
		mask_plan[4] = REL_BIT;
		mask_plan[5] = BYTE_W'($urandom);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty pop, full presses, masked last byte, bounce, releases
		push_pops(1);
		push_scan(0, 8'h00);
		push_scan(0, 8'h00);
		push_scan(SCAN - 1, 8'h00);
		push_scan(SCAN - 1, 8'h00);
		push_pops(3);
		push_scan(0, 8'hAA);
		push_scan(0, ALL_ONES);
		push_scan(0, ALL_ONES);
		push_scan(7, 8'h55);
		push_scan(SCAN - 1, ALL_ONES);
		push_scan(SCAN - 1, ALL_ONES);
		push_pops(10);
		wait_drained();

		for (int phase = 0; phase < 6; phase++) begin
			if (phase > 0)
				write_mask(mask_plan[phase]);
			flood(24);
			random_phase(PHASE_ITEMS);
			// long output stall while the sender still has items queued
			if (phase == 1)
				hold_requests++;
			wait_drained();
		end

		if (errors == 0 && expected_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
